>>> src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expands to one labeled concurrent assertion under clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/imu_fd_pkg.sv
// Shared types and constants for the IMU frame deframer.
// No dependencies; the interfaces and modules of the block import this package.
package imu_fd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CAP_DEPTH = 6;
  localparam int unsigned CAP_IDX_W = $clog2(CAP_DEPTH);

  // Type bytes live in 0x50..0x5F: upper nibble fixed, lower nibble picks mask bit
  localparam logic [3:0] TYPE_HI_NIBBLE = 4'h5;
  localparam logic [LEN_W-1:0] MIN_FRAME = 4'd8;
  localparam logic [LEN_W-1:0] FIRST_CAP_POS = 4'd2;
  localparam logic [LEN_W-1:0] LAST_CAP_POS  = 4'd7;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'h55;
  localparam logic [LEN_W-1:0]  LENGTH_RST = 4'd10;
  localparam logic [MASK_W-1:0] MASK_RST   = 16'h001E;

  typedef enum logic [1:0] {
    CFG_HEADER_BYTE  = 2'd0,
    CFG_FRAME_LENGTH = 2'd1,
    CFG_TYPE_MASK    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_HEADER  = 2'd1,
    ST_COLLECT = 2'd2
  } hunt_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [MASK_W-1:0] type_mask;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic [BYTE_W-1:0]        frame_type;
    logic signed [WORD_W-1:0] first_word;
    logic signed [WORD_W-1:0] second_word;
    logic signed [WORD_W-1:0] third_word;
  } frame_res_t;

endpackage

>>> src/imu_fd_byte_if.sv
// Valid/ready channel carrying one received byte per beat.
// Depends on imu_fd_pkg for widths.
interface imu_fd_byte_if import imu_fd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/imu_fd_frame_if.sv
// Valid/ready channel carrying one decoded frame per beat.
// Depends on imu_fd_pkg for widths.
interface imu_fd_frame_if import imu_fd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BYTE_W-1:0]        frame_type;
  logic signed [WORD_W-1:0] first_word;
  logic signed [WORD_W-1:0] second_word;
  logic signed [WORD_W-1:0] third_word;

  modport source (output valid, output frame_type, output first_word,
                  output second_word, output third_word, input ready);
  modport sink   (input valid, input frame_type, input first_word,
                  input second_word, input third_word, output ready);
endinterface

>>> src/imu_fd_parser.sv
// Frame hunt/collect state machine with running checksum and byte capture.
// Depends on imu_fd_pkg and assert_macros.svh; result is combinational on the beat.
`include "assert_macros.svh"

module imu_fd_parser import imu_fd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output frame_res_t        res
);

  hunt_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] cap_r [CAP_DEPTH];

  logic [LEN_W-1:0]     eff_len;
  logic                 type_ok;
  logic                 hdr_hit;
  logic                 frame_end;
  logic                 cap_we;
  logic [CAP_IDX_W-1:0] cap_idx;
  logic [LEN_W-1:0]     cap_off;
  logic                 res_valid;

  // Decode the current byte against the configuration
  assign eff_len   = (cfg.frame_length < MIN_FRAME) ? MIN_FRAME : cfg.frame_length;
  assign type_ok   = (rx_byte[7:4] == TYPE_HI_NIBBLE) && cfg.type_mask[rx_byte[3:0]];
  assign hdr_hit   = (rx_byte == cfg.header_byte);
  assign frame_end = (pos_r >= eff_len);
  assign cap_off   = pos_r - FIRST_CAP_POS;
  assign cap_idx   = cap_off[CAP_IDX_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (byte_valid) begin
      unique case (state_r)
        ST_COLLECT: state_nxt = frame_end ? ST_HUNT : ST_COLLECT;
        ST_HEADER: begin
          if (type_ok)      state_nxt = ST_COLLECT;
          else if (hdr_hit) state_nxt = ST_HEADER;
          else              state_nxt = ST_HUNT;
        end
        default:            state_nxt = hdr_hit ? ST_HEADER : ST_HUNT;
      endcase
    end
  end

  // Position, checksum, held type, capture strobe and result valid
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    cap_we    = 1'b0;
    res_valid = 1'b0;
    if (byte_valid) begin
      unique case (state_r)
        ST_COLLECT: begin
          if (frame_end) begin
            pos_nxt   = '0;
            sum_nxt   = '0;
            res_valid = (rx_byte == sum_r);
          end else begin
            cap_we  = (pos_r >= FIRST_CAP_POS) && (pos_r <= LAST_CAP_POS);
            sum_nxt = sum_r + rx_byte;
            pos_nxt = pos_r + 4'd1;
          end
        end
        ST_HEADER: begin
          if (type_ok) begin
            type_nxt = rx_byte;
            sum_nxt  = sum_r + rx_byte;
            pos_nxt  = FIRST_CAP_POS;
          end else if (hdr_hit) begin
            sum_nxt = rx_byte;
            pos_nxt = 4'd1;
          end else begin
            sum_nxt = '0;
            pos_nxt = '0;
          end
        end
        default: begin
          if (hdr_hit) begin
            sum_nxt = rx_byte;
            pos_nxt = 4'd1;
          end else begin
            sum_nxt = '0;
            pos_nxt = '0;
          end
        end
      endcase
    end
  end

  // Assemble little-endian words from the captured bytes
  assign res.valid       = res_valid;
  assign res.frame_type  = type_r;
  assign res.first_word  = {cap_r[1], cap_r[0]};
  assign res.second_word = {cap_r[3], cap_r[2]};
  assign res.third_word  = {cap_r[5], cap_r[4]};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      pos_r   <= '0;
      sum_r   <= '0;
      type_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
    end
  end

  // Capture frame bytes 2..7
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_r[cap_idx] <= rx_byte;
    end
  end

  `ASSERT_IMPLIES(a_res_needs_beat, clk, rst_n, res.valid, byte_valid && state_r == ST_COLLECT, "result without a checksum beat")
  `ASSERT_IMPLIES(a_collect_pos, clk, rst_n, state_r == ST_COLLECT, pos_r >= FIRST_CAP_POS, "frame position out of range")
  `ASSERT_NEXT(a_header_pos, clk, rst_n, byte_valid && state_r != ST_COLLECT && hdr_hit && !(state_r == ST_HEADER && type_ok), state_r == ST_HEADER && pos_r == 4'd1, "header not tracked")

endmodule

>>> src/imu_frame_deframer.sv
// IMU frame deframer top level: configuration registers, parser and result register.
// Depends on imu_fd_pkg, imu_fd_byte_if, imu_fd_frame_if, imu_fd_parser, assert_macros.svh.
//
// Usage:
//   in_byte  (sink)   : one received serial byte per beat.
//   out_frame (source): one decoded frame per beat (type and three signed words).
//   cfg_we/cfg_index/cfg_wdata: write header byte (0), frame length (1), type mask (2)
//   while the block is idle.
// Throughput: one byte per cycle unless stalled. The parser state, checksum and capture
//   registers update in the same cycle the byte is taken, so bytes can arrive back to back.
// A frame appears on out_frame in the cycle after its checksum byte is taken.
// A frame with a bad checksum gives no beat; hunting restarts with the next byte.
// Reset (rst_n low, synchronous): parser returns to hunting, the output register
//   empties, and the registers load header 0x55, length 10, type mask 0x001E.
// Stall: a waiting frame holds in the output register; in_byte.ready stays high
//   while that register is empty or being drained, so bytes keep flowing unless a
//   held frame is not taken.
`include "assert_macros.svh"

module imu_frame_deframer import imu_fd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  imu_fd_byte_if.sink      in_byte,
  imu_fd_frame_if.source   out_frame,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  frame_res_t res;
  frame_res_t out_r;
  logic       out_valid_r;
  logic       in_fire;

  // Accept a byte unless a held frame is stalled
  assign in_byte.ready = !out_valid_r || out_frame.ready;
  assign in_fire       = in_byte.valid && in_byte.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte  <= HEADER_RST;
      cfg_r.frame_length <= LENGTH_RST;
      cfg_r.type_mask    <= MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HEADER_BYTE:  cfg_r.header_byte  <= cfg_wdata[BYTE_W-1:0];
        CFG_FRAME_LENGTH: cfg_r.frame_length <= cfg_wdata[LEN_W-1:0];
        CFG_TYPE_MASK:    cfg_r.type_mask    <= cfg_wdata[MASK_W-1:0];
        default:          ;
      endcase
    end
  end

  imu_fd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_fire),
    .rx_byte    (in_byte.rx_byte),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Output valid: load on a good frame, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_frame.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_r <= res;
    end
  end

  assign out_frame.valid       = out_valid_r;
  assign out_frame.frame_type  = out_r.frame_type;
  assign out_frame.first_word  = out_r.first_word;
  assign out_frame.second_word = out_r.second_word;
  assign out_frame.third_word  = out_r.third_word;

  `ASSERT_IMPLIES(a_stall_blocks_in, clk, rst_n, out_valid_r && !out_frame.ready, !in_byte.ready, "byte taken while frame stalled")
  `ASSERT_NEXT(a_res_loads_out, clk, rst_n, res.valid, out_valid_r, "good frame not registered")
  `ASSERT_IMPLIES(a_res_on_fire, clk, rst_n, res.valid, in_fire, "result without accepted byte")

endmodule
